// ----- rtl/gbn_pkg.sv -----
// shared types, constants and checksum helpers for the go-back-n endpoint
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

    // retransmission buffer depth as seen by the protocol
    localparam int BUF_DEPTH = 8;
    // at most this many packets are ever outstanding or resent in one run
    localparam int MAX_OUT   = (BUF_DEPTH < 8) ? BUF_DEPTH : 8;
    // the outstanding run is at most MAX_OUT consecutive sequence numbers, so the
    // low sequence bits address a power-of-two store without aliasing
    localparam int BUF_AW    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int RAM_DEPTH = 1 << BUF_AW;
    localparam int CNT_W     = 4;

    localparam int SEQ_W     = 24;
    localparam int CHK_W     = 16;
    localparam int S_DATA_W  = 224;
    localparam int M_DATA_W  = 232;

    localparam logic [SEQ_W-1:0] SEQ_MAX     = 24'hFF_FFFF;
    localparam logic [SEQ_W-1:0] NO_ACK      = 24'd999;
    localparam logic [SEQ_W-1:0] SEQ_START   = 24'd1;
    localparam logic [CNT_W-1:0] MAX_OUT_CNT = CNT_W'(MAX_OUT);
    localparam logic [3:0]       WIN_RESET   = 4'd8;
    localparam logic [15:0]      TMO_RESET   = 16'd30;

    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_RECV = 2'd1,
        ACT_TICK = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        KIND_TX      = 3'd0,
        KIND_RETX    = 3'd1,
        KIND_DELIVER = 3'd2,
        KIND_DROP    = 3'd3,
        KIND_CORRUPT = 3'd4,
        KIND_OOO     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ACKR_NONE  = 2'd0,
        ACKR_OK    = 2'd1,
        ACKR_STALE = 2'd2
    } ack_res_t;

    typedef enum logic [0:0] {
        REG_WINDOW_SIZE   = 1'b0,
        REG_TIMEOUT_TICKS = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RS_RD,
        ST_RS_OUT
    } state_t;

    // one buffered packet
    typedef struct packed {
        logic [31:0]      lo;
        logic [63:0]      mid;
        logic [63:0]      hi;
        logic [CHK_W-1:0] check;
        logic [SEQ_W-1:0] ack;
        logic [SEQ_W-1:0] seq;
    } buf_entry_t;

    // one result beat held in the output register
    typedef struct packed {
        kind_t            kind;
        ack_res_t         ack_res;
        logic             last;
        buf_entry_t       pkt;
    } out_beat_t;

    // sum of the ten 16-bit payload words
    function automatic logic [19:0] payload_sum(input logic [63:0] hi,
                                                input logic [63:0] mid,
                                                input logic [31:0] lo);
        logic [19:0] s;
        s = {4'b0, lo[15:0]} + {4'b0, lo[31:16]};
        for (int i = 0; i < 4; i++) begin
            s = s + {4'b0, hi[16*i +: 16]} + {4'b0, mid[16*i +: 16]};
        end
        return s;
    endfunction

    // end-around-carry fold to 16 bits, then complement
    function automatic logic [CHK_W-1:0] fold_check(input logic [25:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, s[15:0]} + {7'b0, s[25:16]};
        f2 = {1'b0, f1[15:0]} + {16'b0, f1[16]};
        return ~f2[15:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/gbn_ram.sv -----
// simple dual-port ram with registered read for the retransmission buffer
`timescale 1ns / 1ps
`default_nettype none
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output      logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/go_back_n_endpoint_core.sv -----
// go-back-n endpoint with piggybacked acks: control, checksum and buffer
//
// input stream s_*: one beat per request; s_tuser carries the action
// (send, receive, tick), s_tdata the packet header and 20-byte payload.
// output stream m_*: result beats; m_tuser carries the result kind, m_tlast
// marks the final beat caused by one request.
// config port: cfg_we writes cfg_data into register cfg_index (0 window
// size, 1 timeout ticks); write only while the block is idle.
// timing: a beat is taken in the idle state and handled in the execute state
// once the output register is free; each result is held in the output register.
// a timeout resends up to 8 packets, each one read from the buffer ram in the
// read state and then sent from the output state.
// s_tready is low while an item or a resend run is in progress.
// stall: a result waits in the output register until m_tready; the next
// input beat is still taken, and is handled once the register frees up.
// reset: window base, next and expected sequence start at 1, timer stopped,
// window size 8, timeout 30; the buffer ram is not cleared and needs no pass.
`timescale 1ns / 1ps
`default_nettype none
module go_back_n_endpoint_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // seq, ack, check, data_hi, data_mid, data_lo (lowest bit up)
    input  wire logic [gbn_pkg::S_DATA_W-1:0]  s_tdata,
    // action
    input  wire logic [1:0]                    s_tuser,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // out_seq, out_ack, out_check, out_data_hi, out_data_mid, out_data_lo,
    // ack_result, zero fill (lowest bit up)
    output      logic [gbn_pkg::M_DATA_W-1:0]  m_tdata,
    // kind
    output      logic [2:0]                    m_tuser,
    output      logic                          m_tlast,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import gbn_pkg::*;

    state_t           state_reg, state_next;
    logic [3:0]       window_size_reg;
    logic [15:0]      timeout_reg;

    action_t          act_reg;
    logic [SEQ_W-1:0] in_seq_reg;
    logic [SEQ_W-1:0] in_ack_reg;
    logic [CHK_W-1:0] in_chk_reg;
    logic [63:0]      in_hi_reg;
    logic [63:0]      in_mid_reg;
    logic [31:0]      in_lo_reg;
    logic [19:0]      psum_reg;

    logic [SEQ_W-1:0] base_reg, base_next;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0] exp_seq_reg, exp_seq_next;
    logic             ack_pend_reg, ack_pend_next;
    logic [SEQ_W-1:0] ack_val_reg, ack_val_next;
    logic             tmr_run_reg, tmr_run_next;
    logic [15:0]      tmr_cnt_reg, tmr_cnt_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             out_valid_reg, out_valid_next;
    out_beat_t        out_beat_reg, out_beat_next;

    logic             in_fire;
    logic             out_free;
    logic [SEQ_W-1:0] tx_ack;
    logic [SEQ_W-1:0] hdr_seq;
    logic [SEQ_W-1:0] hdr_ack;
    logic [CHK_W-1:0] hdr_chk;
    logic [25:0]      chk_sum;
    logic [CHK_W-1:0] chk_val;
    logic [3:0]       win_eff;
    logic             win_full;
    logic [SEQ_W-1:0] new_base;
    logic [15:0]      tmr_inc;
    logic [15:0]      tmr_limit;
    logic [SEQ_W-1:0] out_diff;
    logic [CNT_W-1:0] out_cnt;

    logic             ram_we;
    logic             ram_re;
    logic [BUF_AW-1:0] ram_raddr;
    buf_entry_t       ram_wdata;
    buf_entry_t       ram_rdata;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // output ports
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_beat_reg.kind;
    assign m_tlast  = out_beat_reg.last;
    assign m_tdata  = {6'b0, out_beat_reg.ack_res, out_beat_reg.pkt};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_RESET;
            timeout_reg     <= TMO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW_SIZE:   window_size_reg <= cfg_data[3:0];
                REG_TIMEOUT_TICKS: timeout_reg     <= cfg_data;
            endcase
        end
    end

    // input capture with payload word sum
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg    <= action_t'(s_tuser);
            in_seq_reg <= s_tdata[23:0];
            in_ack_reg <= s_tdata[47:24];
            in_chk_reg <= s_tdata[63:48];
            in_hi_reg  <= s_tdata[127:64];
            in_mid_reg <= s_tdata[191:128];
            in_lo_reg  <= s_tdata[223:192];
            psum_reg   <= payload_sum(s_tdata[127:64], s_tdata[191:128],
                                      s_tdata[223:192]);
        end
    end

    // header words feeding the checksum
    assign tx_ack  = ack_pend_reg ? ack_val_reg : NO_ACK;
    assign hdr_seq = (act_reg == ACT_SEND) ? next_seq_reg : in_seq_reg;
    assign hdr_ack = (act_reg == ACT_SEND) ? tx_ack : in_ack_reg;
    assign hdr_chk = (act_reg == ACT_SEND) ? '0 : in_chk_reg;
    assign chk_sum = {6'b0, psum_reg} + {2'b0, hdr_seq} + {2'b0, hdr_ack}
                   + {10'b0, hdr_chk};
    assign chk_val = fold_check(chk_sum);

    // window and timer arithmetic
    assign win_eff  = (window_size_reg > 4'(MAX_OUT)) ? 4'(MAX_OUT) : window_size_reg;
    assign win_full = (next_seq_reg == SEQ_MAX)
                   || ({1'b0, next_seq_reg} >= ({1'b0, base_reg} + {21'b0, win_eff}));
    assign new_base = (in_ack_reg == SEQ_MAX) ? SEQ_MAX : in_ack_reg + 24'd1;
    assign tmr_inc  = (tmr_cnt_reg != 16'hFFFF) ? tmr_cnt_reg + 16'd1 : tmr_cnt_reg;
    assign tmr_limit = (timeout_reg == '0) ? 16'd1 : timeout_reg;
    assign out_diff = (next_seq_reg > base_reg) ? next_seq_reg - base_reg : '0;
    assign out_cnt  = (out_diff > {20'b0, MAX_OUT_CNT}) ? MAX_OUT_CNT
                                                         : out_diff[CNT_W-1:0];

    // buffer ram ports
    assign ram_wdata.seq   = next_seq_reg;
    assign ram_wdata.ack   = tx_ack;
    assign ram_wdata.check = chk_val;
    assign ram_wdata.hi    = in_hi_reg;
    assign ram_wdata.mid   = in_mid_reg;
    assign ram_wdata.lo    = in_lo_reg;
    assign ram_re    = (state_reg == ST_RS_RD);
    assign ram_raddr = base_reg[BUF_AW-1:0] + k_reg[BUF_AW-1:0];

    gbn_ram #(
        .WIDTH ($bits(buf_entry_t)),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (next_seq_reg[BUF_AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer: next state, protocol state updates and result beats
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        next_seq_next  = next_seq_reg;
        exp_seq_next   = exp_seq_reg;
        ack_pend_next  = ack_pend_reg;
        ack_val_next   = ack_val_reg;
        tmr_run_next   = tmr_run_reg;
        tmr_cnt_next   = tmr_cnt_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        out_beat_next  = out_beat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ram_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    unique case (act_reg)
                        ACT_SEND:
                        begin
                            out_valid_next = 1'b1;
                            if (win_full)
                            begin
                                out_beat_next      = '0;
                                out_beat_next.kind = KIND_DROP;
                                out_beat_next.last = 1'b1;
                            end
                            else
                            begin
                                ram_we                = 1'b1;
                                out_beat_next.kind    = KIND_TX;
                                out_beat_next.ack_res = ACKR_NONE;
                                out_beat_next.last    = 1'b1;
                                out_beat_next.pkt     = ram_wdata;
                                ack_pend_next         = 1'b0;
                                if (base_reg == next_seq_reg && !tmr_run_reg)
                                begin
                                    tmr_run_next = 1'b1;
                                    tmr_cnt_next = '0;
                                end
                                next_seq_next = next_seq_reg + 24'd1;
                            end
                        end

                        ACT_RECV:
                        begin
                            out_valid_next          = 1'b1;
                            out_beat_next.last      = 1'b1;
                            out_beat_next.ack_res   = ACKR_NONE;
                            out_beat_next.pkt.seq   = in_seq_reg;
                            out_beat_next.pkt.ack   = in_ack_reg;
                            out_beat_next.pkt.check = in_chk_reg;
                            out_beat_next.pkt.hi    = in_hi_reg;
                            out_beat_next.pkt.mid   = in_mid_reg;
                            out_beat_next.pkt.lo    = in_lo_reg;
                            if (chk_val != '0)
                            begin
                                out_beat_next.kind = KIND_CORRUPT;
                            end
                            else
                            begin
                                if (in_seq_reg == exp_seq_reg)
                                begin
                                    out_beat_next.kind = KIND_DELIVER;
                                    ack_val_next       = exp_seq_reg;
                                    ack_pend_next      = 1'b1;
                                    if (exp_seq_reg != SEQ_MAX)
                                    begin
                                        exp_seq_next = exp_seq_reg + 24'd1;
                                    end
                                end
                                else
                                begin
                                    out_beat_next.kind = KIND_OOO;
                                end
                                // piggybacked ack slides the window
                                if (in_ack_reg != NO_ACK)
                                begin
                                    if (base_reg > in_ack_reg)
                                    begin
                                        out_beat_next.ack_res = ACKR_STALE;
                                    end
                                    else
                                    begin
                                        out_beat_next.ack_res = ACKR_OK;
                                        base_next             = new_base;
                                        if (new_base == next_seq_reg)
                                        begin
                                            tmr_run_next = 1'b0;
                                        end
                                        else
                                        begin
                                            tmr_run_next = 1'b1;
                                            tmr_cnt_next = '0;
                                        end
                                    end
                                end
                            end
                        end

                        ACT_TICK:
                        begin
                            if (tmr_run_reg)
                            begin
                                tmr_cnt_next = tmr_inc;
                                if (tmr_inc >= tmr_limit)
                                begin
                                    tmr_cnt_next = '0;
                                    k_next       = '0;
                                    n_next       = out_cnt;
                                    if (out_cnt != '0)
                                    begin
                                        state_next = ST_RS_RD;
                                    end
                                end
                            end
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RS_RD:
            begin
                state_next = ST_RS_OUT;
            end

            ST_RS_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_beat_next.kind    = KIND_RETX;
                    out_beat_next.ack_res = ACKR_NONE;
                    out_beat_next.pkt     = ram_rdata;
                    out_beat_next.last    = ((k_reg + 4'd1) == n_reg);
                    k_next                = k_reg + 4'd1;
                    state_next = ((k_reg + 4'd1) == n_reg) ? ST_IDLE : ST_RS_RD;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= SEQ_START;
            next_seq_reg  <= SEQ_START;
            exp_seq_reg   <= SEQ_START;
            ack_pend_reg  <= 1'b0;
            ack_val_reg   <= '0;
            tmr_run_reg   <= 1'b0;
            tmr_cnt_reg   <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            next_seq_reg  <= next_seq_next;
            exp_seq_reg   <= exp_seq_next;
            ack_pend_reg  <= ack_pend_next;
            ack_val_reg   <= ack_val_next;
            tmr_run_reg   <= tmr_run_next;
            tmr_cnt_reg   <= tmr_cnt_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

endmodule
`default_nettype wire

// ----- rtl/gbn_chk.sv -----
// port-level checks for the go-back-n endpoint, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module gbn_chk (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [gbn_pkg::M_DATA_W-1:0]  m_tdata,
    input  wire logic [2:0]                    m_tuser,
    input  wire logic                          m_tlast,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready
);
    import gbn_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a window full drop carries nothing but its kind and last
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_DROP |-> m_tdata == '0 && m_tlast)
        else $error("window full drop carries data");

    // only a resend run can span several beats
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_RETX |-> m_tlast)
        else $error("non-resend result without last");

    // sent packets carry no ack result
    a_tx_no_ackres: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_TX || m_tuser == KIND_RETX)
        |-> m_tdata[225:224] == ACKR_NONE)
        else $error("sent packet with ack result");

endmodule

bind go_back_n_endpoint_core gbn_chk u_gbn_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire
